// ===== rtl/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared sizes, register indexes, reset values and the line store word of
// the contrast pixel counter.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 10;
  localparam int THR_W      = 8;
  localparam int COUNT_W    = 19;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam int MAX_COUNT  = MAX_WIDTH * MAX_HEIGHT;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 10'd320;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 10'd200;
  localparam logic [THR_W-1:0] THRESHOLD_RESET    = 8'd128;

  // One entry of the line store: a pixel of the previous row and its
  // settled contrast flag (left, right and up already checked).
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flag;
  } line_word_t;

endpackage

// ===== rtl/contrast_pixel_counter.sv =====
// ----------------------------------------------------------------------------
// contrast_pixel_counter
// Counts the pixels of a raster frame that differ from any of their
// four neighbours by more than a threshold.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and, with the frame's last
// pixel, hands out the number of contrasting pixels in that frame in the next
// cycle; the next frame starts with the following pixel. The rate of one
// pixel a clock is set by the line store, a single memory of MAX_WIDTH words
// of 9 bits (pixel and flag of the row above) that is read one column ahead
// and written one column behind, so each pixel costs one read and one write.
// The input stalls only when a frame's last pixel arrives while the previous
// count still waits at the output. The memory needs no clearing after reset.
// A write to any of the three registers restarts the frame and drops the partial count.
// ----------------------------------------------------------------------------
module contrast_pixel_counter
  import cpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    contrast_count
);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [THR_W-1:0]   contrast_threshold;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [COUNT_W-1:0] running_count;
  logic [PIX_W-1:0]   left_pixel;
  logic               left_flag;
  logic               byp_hit;
  line_word_t         byp_word;

  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic [DIM_W-1:0]   width_m1;
  logic [DIM_W-1:0]   height_m1;
  logic [COL_W-1:0]   col_last;
  logic [ROW_W-1:0]   row_last;
  logic               first_col;
  logic               first_row;
  logic               at_last_col;
  logic               at_last_row;
  logic               frame_end;
  logic               in_accept;

  line_word_t         rd_word;
  line_word_t         above;
  line_word_t         wr_word;
  logic               wr_en;
  logic [COL_W-1:0]   wr_addr;
  logic [COL_W-1:0]   rd_addr;

  logic               diff_left;
  logic               diff_up;
  logic               cur_flag;
  logic               left_full;
  logic               inc_above;
  logic               inc_left;
  logic               inc_cur;
  logic [1:0]         inc;
  logic [COUNT_W-1:0] count_sum;

  function automatic logic exceeds(input logic [PIX_W-1:0] a,
                                   input logic [PIX_W-1:0] b,
                                   input logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

  // Out-of-range sizes act as the nearest legal one.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  assign width_m1    = width_eff - DIM_W'(1);
  assign height_m1   = height_eff - DIM_W'(1);
  assign col_last    = COL_W'(width_m1);
  assign row_last    = ROW_W'(height_m1);
  assign first_col   = (col == '0);
  assign first_row   = (row == '0);
  assign at_last_col = (col == col_last);
  assign at_last_row = (row == row_last);
  assign frame_end   = at_last_col && at_last_row;

  // Hold the input only when a count is due while the last one is stalled.
  assign in_stall  = out_valid && out_stall && frame_end;
  assign in_accept = in_valid && !in_stall;

  // In a one-column frame the pixel above is the previous item itself.
  always_comb begin
    if (width_eff == DIM_W'(1)) begin
      above = line_word_t'({left_pixel, left_flag});
    end else if (byp_hit) begin
      above = byp_word;
    end else begin
      above = rd_word;
    end
  end

  always_comb begin
    diff_left = !first_col && exceeds(pixel, left_pixel, contrast_threshold);
    diff_up   = !first_row && exceeds(pixel, above.pixel, contrast_threshold);
    cur_flag  = diff_left || diff_up;
    left_full = left_flag || diff_left;

    // The pixel above has seen its last neighbour; in the last row the
    // pixel to the left settles too, and the row's last pixel at once.
    inc_above = !first_row && (above.flag || diff_up);
    inc_left  = at_last_row && !first_col && left_full;
    inc_cur   = at_last_row && at_last_col && cur_flag;
    inc       = 2'({1'b0, inc_above}) + 2'({1'b0, inc_left}) + 2'({1'b0, inc_cur});
    count_sum = running_count + COUNT_W'(inc);
  end

  // Write the left neighbour one column behind; the last column of a row
  // goes out with the first item of the next row.
  always_comb begin
    wr_en   = in_accept && !(first_col && first_row);
    wr_addr = first_col ? col_last : (col - COL_W'(1));
    wr_word = line_word_t'({left_pixel, (first_col ? left_flag : left_full)});
    rd_addr = at_last_col ? '0 : (col + COL_W'(1));
  end

  cpc_ram #(
    .WIDTH ($bits(line_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width        <= FRAME_WIDTH_RESET;
      frame_height       <= FRAME_HEIGHT_RESET;
      contrast_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:        frame_width        <= cfg_data;
        REG_FRAME_HEIGHT:       frame_height       <= cfg_data;
        REG_CONTRAST_THRESHOLD: contrast_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame position, running count, left neighbour flag and bypass hit flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      running_count <= '0;
      left_flag     <= 1'b0;
      byp_hit       <= 1'b0;
    end else if (cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                               cfg_index == REG_FRAME_HEIGHT ||
                               cfg_index == REG_CONTRAST_THRESHOLD)) begin
      col           <= '0;
      row           <= '0;
      running_count <= '0;
      left_flag     <= 1'b0;
    end else if (in_accept) begin
      left_flag <= cur_flag;
      byp_hit   <= wr_en && (wr_addr == rd_addr);
      if (at_last_col) begin
        col <= '0;
        if (at_last_row) begin
          row           <= '0;
          running_count <= '0;
        end else begin
          row           <= row + ROW_W'(1);
          running_count <= count_sum;
        end
      end else begin
        col           <= col + COL_W'(1);
        running_count <= count_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_pixel <= pixel;
      byp_word   <= wr_word;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && frame_end && !cfg_write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_end) begin
      contrast_count <= count_sum;
    end
  end

endmodule

// ===== rtl/cpc_ram.sv =====
// ----------------------------------------------------------------------------
// cpc_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module cpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cpc_checker.sv =====
// ----------------------------------------------------------------------------
// cpc_checker
// Port-level checks of the contrast pixel counter, bound to its top level.
// ----------------------------------------------------------------------------
module cpc_checker
  import cpc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cfg_write,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COUNT_W-1:0] contrast_count
);

  // A count waiting at a stalled output stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(contrast_count))
    else $error("stalled count changed or vanished");

  // The input is only held back by a stalled count.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled count");

  // A count never exceeds the number of pixels in the largest frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> contrast_count <= COUNT_W'(MAX_COUNT))
    else $error("count exceeds frame size");

  // Reset leaves no count at the output.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("count present after reset");

  // A register write restarts the frame, so it finishes none.
  assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !$rose(out_valid))
    else $error("count produced by a register write");

endmodule

bind contrast_pixel_counter cpc_checker u_cpc_checker (.*);
